// ===== rtl/core/vgsd_pkg.sv =====
// ----------------------------------------------------------------------------
// vgsd_pkg : shared types and constants of the vector glyph stream decoder
// Command codes, parser phase codes and the command beat that travels from
// the parser through the queue to the point unit.
// ----------------------------------------------------------------------------
package vgsd_pkg;

  // Field widths fixed by the stream format
  localparam int BYTE_W     = 8;
  localparam int GLYPH_W    = 17;
  localparam int POINT_W    = 12;
  localparam int ORIGIN_W   = 8;
  localparam int SCALE_W    = 3;
  localparam int PAIR_W     = 10;
  localparam int CHAR_CNT_W = 3;   // covers the widest field of five characters
  localparam int CFG_IDX_W  = 2;

  // Default configuration
  localparam int DEF_GLYPH_FIELD_CHARS = 5;
  localparam int DEF_COUNT_FIELD_CHARS = 3;
  localparam int DEF_QUEUE_DEPTH       = 2;

  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 8'd127;
  localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 8'd95;
  localparam logic [SCALE_W-1:0]  SCALE_RST    = 3'd2;

  // Stream characters
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_SCALE    = 2'd2
  } cfg_idx_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_DRAW  = 2'd2
  } kind_t;

  // Parser phases, one-hot
  typedef enum logic [2:0] {
    PH_GLYPH = 3'b001,
    PH_COUNT = 3'b010,
    PH_PAIRS = 3'b100
  } phase_t;

  // Command beat from parser to point unit
  typedef struct packed {
    kind_t               kind;
    logic [GLYPH_W-1:0]  glyph_number;
    logic [BYTE_W-1:0]   x_char;
    logic [BYTE_W-1:0]   y_char;
  } cmd_t;

  // Live configuration seen by the point unit
  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [SCALE_W-1:0]  scale;
  } cfg_t;

endpackage

// ===== rtl/core/vgsd_front.sv =====
// ----------------------------------------------------------------------------
// vgsd_front : stream parser
// Consumes one byte per beat, tracks the glyph number, pair count and
// coordinate pair fields, and issues glyph start and point commands.
// ----------------------------------------------------------------------------
module vgsd_front
  import vgsd_pkg::*;
#(
  parameter int GLYPH_FIELD_CHARS = DEF_GLYPH_FIELD_CHARS,
  parameter int COUNT_FIELD_CHARS = DEF_COUNT_FIELD_CHARS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] byte_in,
  output logic              push,
  output cmd_t              cmd
);

  phase_t               phase_r,   phase_nxt;
  logic [CHAR_CNT_W-1:0] chars_r,  chars_nxt;
  logic [GLYPH_W-1:0]   acc_r,     acc_nxt;
  logic [PAIR_W-1:0]    total_r,   total_nxt;
  logic [PAIR_W-1:0]    seen_r,    seen_nxt;
  logic [BYTE_W-1:0]    held_x_r,  held_x_nxt;
  logic                 have_x_r,  have_x_nxt;
  logic                 pen_up_r,  pen_up_nxt;

  logic                  is_digit;
  logic                  is_eol;
  logic [GLYPH_W-1:0]    acc_add;
  logic [CHAR_CNT_W-1:0] chars_add;
  logic [PAIR_W-1:0]     seen_inc;

  // Accumulate one character into the decimal field
  assign is_eol    = (byte_in == CHAR_LF) || (byte_in == CHAR_CR);
  assign is_digit  = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
  assign acc_add   = is_digit ?
                     GLYPH_W'(acc_r * GLYPH_W'(10) + GLYPH_W'(byte_in - CHAR_ZERO)) :
                     acc_r;
  assign chars_add = chars_r + CHAR_CNT_W'(1);
  assign seen_inc  = seen_r + PAIR_W'(1);

  // Advance the parser on each accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    chars_nxt  = chars_r;
    acc_nxt    = acc_r;
    total_nxt  = total_r;
    seen_nxt   = seen_r;
    held_x_nxt = held_x_r;
    have_x_nxt = have_x_r;
    pen_up_nxt = pen_up_r;
    push       = 1'b0;
    cmd        = '{kind: KIND_GLYPH, glyph_number: acc_add, x_char: byte_in, y_char: byte_in};
    cmd.x_char = held_x_r;
    if (accept && !is_eol) begin
      unique case (phase_r)
        PH_COUNT: begin
          acc_nxt   = acc_add;
          chars_nxt = chars_add;
          if (chars_add >= CHAR_CNT_W'(COUNT_FIELD_CHARS)) begin
            total_nxt  = acc_add[PAIR_W-1:0];
            seen_nxt   = '0;
            acc_nxt    = '0;
            chars_nxt  = '0;
            have_x_nxt = 1'b0;
            pen_up_nxt = 1'b1;
            phase_nxt  = (acc_add[PAIR_W-1:0] == '0) ? PH_GLYPH : PH_PAIRS;
          end
        end
        PH_PAIRS: begin
          if (!have_x_r) begin
            held_x_nxt = byte_in;
            have_x_nxt = 1'b1;
          end else begin
            have_x_nxt = 1'b0;
            seen_nxt   = seen_inc;
            if (seen_inc >= total_r) begin
              phase_nxt = PH_GLYPH;
              seen_nxt  = '0;
            end
            if (seen_r != '0) begin
              // Pen-up pair lifts the pen, any other pair is a point
              if (held_x_r == CHAR_SPACE && byte_in == CHAR_R) begin
                pen_up_nxt = 1'b1;
              end else begin
                push              = 1'b1;
                cmd.kind          = pen_up_r ? KIND_MOVE : KIND_DRAW;
                cmd.glyph_number  = '0;
                pen_up_nxt        = 1'b0;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_GLYPH;
          acc_nxt   = acc_add;
          chars_nxt = chars_add;
          if (chars_add >= CHAR_CNT_W'(GLYPH_FIELD_CHARS)) begin
            push      = 1'b1;
            acc_nxt   = '0;
            chars_nxt = '0;
            phase_nxt = PH_COUNT;
          end
        end
      endcase
    end
  end

  // Hold the parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_GLYPH;
      chars_r  <= '0;
      acc_r    <= '0;
      total_r  <= '0;
      seen_r   <= '0;
      held_x_r <= '0;
      have_x_r <= 1'b0;
      pen_up_r <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      chars_r  <= chars_nxt;
      acc_r    <= acc_nxt;
      total_r  <= total_nxt;
      seen_r   <= seen_nxt;
      held_x_r <= held_x_nxt;
      have_x_r <= have_x_nxt;
      pen_up_r <= pen_up_nxt;
    end
  end

endmodule

// ===== rtl/core/vgsd_queue.sv =====
// ----------------------------------------------------------------------------
// vgsd_queue : command queue
// Short first-in first-out store between the parser and the point unit.
// ----------------------------------------------------------------------------
module vgsd_queue
  import vgsd_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/core/vgsd_back.sv =====
// ----------------------------------------------------------------------------
// vgsd_back : point unit and output register
// Takes commands from the queue, scales and offsets point coordinates and
// presents the result beat until it is taken.
// ----------------------------------------------------------------------------
module vgsd_back
  import vgsd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      q_not_empty,
  input  cmd_t                      q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [GLYPH_W-1:0]        out_glyph_number,
  output logic signed [POINT_W-1:0] out_point_x,
  output logic signed [POINT_W-1:0] out_point_y
);

  localparam int SUM_W = POINT_W + 1;

  logic                      valid_r, valid_nxt;
  logic [1:0]                kind_r;
  logic [GLYPH_W-1:0]        glyph_r;
  logic signed [POINT_W-1:0] x_r, y_r;
  logic signed [POINT_W-1:0] x_calc, y_calc;
  logic                      is_glyph;

  // Map a raw character to a screen coordinate
  function automatic logic signed [POINT_W-1:0] place(
    input logic [ORIGIN_W-1:0] origin,
    input logic [SCALE_W-1:0]  scale,
    input logic [BYTE_W-1:0]   c
  );
    logic signed [SUM_W-1:0] raw;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;
    raw  = $signed({{(SUM_W-BYTE_W){1'b0}}, c}) - $signed(SUM_W'({1'b0, CHAR_R}));
    prod = SUM_W'(raw * $signed({{(SUM_W-SCALE_W){1'b0}}, scale}));
    sum  = prod + $signed({{(SUM_W-ORIGIN_W){1'b0}}, origin});
    return sum[POINT_W-1:0];
  endfunction

  assign is_glyph = (q_head.kind == KIND_GLYPH);
  assign x_calc   = is_glyph ? '0 : place(cfg.origin_x, cfg.scale, q_head.x_char);
  assign y_calc   = is_glyph ? '0 : place(cfg.origin_y, cfg.scale, q_head.y_char);

  // Load the output register when it is empty or being drained
  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign valid_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r  <= q_head.kind;
      glyph_r <= q_head.glyph_number;
      x_r     <= x_calc;
      y_r     <= y_calc;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_glyph_number = glyph_r;
  assign out_point_x      = x_r;
  assign out_point_y      = y_r;

`ifndef NO_ASSERTIONS
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |-> !q_pop)
    else $error("output overwritten while stalled");
  a_glyph_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r == KIND_GLYPH) |-> (x_r == '0 && y_r == '0))
    else $error("glyph start carries a point");
  a_point_no_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != KIND_GLYPH) |-> (glyph_r == '0))
    else $error("point carries a glyph number");
`endif

endmodule

// ===== rtl/core/vector_glyph_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// vector_glyph_stream_decoder_top : vector font stream decoder
// Parses a byte stream of vector glyph records into glyph start, move and
// draw beats with configurable origin and scale.
// ----------------------------------------------------------------------------
// The decoder takes one stream byte per clock cycle and keeps that rate as
// long as results are taken; the figure is set by the parser, whose field
// state is updated once per byte. The parser writes the command for the
// byte that completes a result beat into a two-entry queue, and the point
// unit scales the coordinates on its way from that queue into the output
// register. in_ready drops only when that queue is full.
// CR and LF bytes are consumed and dropped. Configuration registers take
// effect on the points computed after the write and should be written while
// no beats are in flight. There is no start-up pass after reset.
// ----------------------------------------------------------------------------
module vector_glyph_stream_decoder_top
  import vgsd_pkg::*;
#(
  parameter int GLYPH_FIELD_CHARS = DEF_GLYPH_FIELD_CHARS,
  parameter int COUNT_FIELD_CHARS = DEF_COUNT_FIELD_CHARS,
  parameter int QUEUE_DEPTH       = DEF_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [BYTE_W-1:0]         in_byte_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [GLYPH_W-1:0]        out_glyph_number,
  output logic signed [POINT_W-1:0] out_point_x,
  output logic signed [POINT_W-1:0] out_point_y,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [ORIGIN_W-1:0]       cfg_wdata
);

  cfg_t cfg_r;
  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  cmd_t q_head;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= ORIGIN_X_RST;
      cfg_r.origin_y <= ORIGIN_Y_RST;
      cfg_r.scale    <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: cfg_r.origin_x <= cfg_wdata;
        CFG_ORIGIN_Y: cfg_r.origin_y <= cfg_wdata;
        CFG_SCALE:    cfg_r.scale    <= cfg_wdata[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  vgsd_front #(
    .GLYPH_FIELD_CHARS (GLYPH_FIELD_CHARS),
    .COUNT_FIELD_CHARS (COUNT_FIELD_CHARS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_byte_in),
    .push    (push),
    .cmd     (push_cmd)
  );

  vgsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  vgsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_glyph_number (out_glyph_number),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y)
  );

endmodule

// ===== tb/glyph_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_stream_checker : result predictor and scoreboard for the decoder
// Watches the byte, result and configuration ports of the vector glyph
// stream decoder. It keeps its own copy of the parser state and registers,
// predicts the beat, if any, caused by each accepted byte, and compares every result
// beat with the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_stream_checker
  import vgsd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [BYTE_W-1:0]         in_byte_in,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [1:0]                out_kind,
  input  logic [GLYPH_W-1:0]        out_glyph_number,
  input  logic signed [POINT_W-1:0] out_point_x,
  input  logic signed [POINT_W-1:0] out_point_y,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [ORIGIN_W-1:0]       cfg_wdata,
  output int                        fail_count,
  output int                        beats_waiting
);

  localparam int GLYPH_CHARS = DEF_GLYPH_FIELD_CHARS;
  localparam int COUNT_CHARS = DEF_COUNT_FIELD_CHARS;

  typedef struct packed {
    kind_t              kind;
    logic [GLYPH_W-1:0] glyph_number;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
  } glyph_beat_t;

  glyph_beat_t expected_beats[$];

  // Mirrored registers
  logic [ORIGIN_W-1:0] origin_x_q;
  logic [ORIGIN_W-1:0] origin_y_q;
  logic [SCALE_W-1:0]  scale_q;

  // Mirrored parser state
  phase_t               phase;
  logic [CHAR_CNT_W-1:0] field_chars;
  logic [GLYPH_W-1:0]   number_acc;
  logic [PAIR_W-1:0]    pairs_total;
  logic [PAIR_W-1:0]    pairs_seen;
  logic [BYTE_W-1:0]    held_x;
  bit                   have_x;
  bit                   pen_lifted;

  int failures = 0;

  // Decimal accumulate: only digits add to the value, modulo the field width
  function automatic logic [GLYPH_W-1:0] push_digit(logic [GLYPH_W-1:0] acc,
                                                    logic [BYTE_W-1:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE)
      return acc * 17'd10 + {9'd0, c - CHAR_ZERO};
    return acc;
  endfunction

  // Screen coordinate: origin plus scale times the offset from 'R'
  function automatic logic [POINT_W-1:0] place_point(logic [ORIGIN_W-1:0] origin,
                                                     logic [BYTE_W-1:0] c,
                                                     logic [SCALE_W-1:0] scale);
    int v;
    v = int'(origin) + int'(scale) * (int'(c) - int'(CHAR_R));
    return v[POINT_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    glyph_beat_t want;
    glyph_beat_t fresh;
    logic [BYTE_W-1:0] c;
    bit emit;
    bit first_pair;
    if (!rst_n) begin
      origin_x_q  = ORIGIN_X_RST;
      origin_y_q  = ORIGIN_Y_RST;
      scale_q     = SCALE_RST;
      phase       = PH_GLYPH;
      field_chars = '0;
      number_acc  = '0;
      pairs_total = '0;
      pairs_seen  = '0;
      held_x      = '0;
      have_x      = 1'b0;
      pen_lifted  = 1'b1;
      expected_beats.delete();
    end else begin
      // Track register writes; unknown indexes change nothing
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X: origin_x_q = cfg_wdata;
          CFG_ORIGIN_Y: origin_y_q = cfg_wdata;
          CFG_SCALE:    scale_q    = cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end

      // Compare a result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected beat: kind %0d glyph %0d x %0d y %0d", out_kind,
                     out_glyph_number, out_point_x, out_point_y);
        end else begin
          want = expected_beats.pop_front();
          if (out_kind !== want.kind || out_glyph_number !== want.glyph_number ||
              out_point_x !== want.point_x || out_point_y !== want.point_y) begin
            failures++;
            if (failures <= 10)
              $display({"mismatch: expected kind %0d glyph %0d x %0d y %0d, ",
                        "got kind %0d glyph %0d x %0d y %0d"},
                       want.kind, want.glyph_number, $signed(want.point_x),
                       $signed(want.point_y), out_kind, out_glyph_number,
                       out_point_x, out_point_y);
          end
        end
      end

      // Advance the parser copy on each accepted byte; drop CR and LF
      if (in_valid && in_ready && in_byte_in != CHAR_LF && in_byte_in != CHAR_CR) begin
        c     = in_byte_in;
        emit  = 1'b0;
        fresh = '0;
        case (phase)
          PH_COUNT: begin
            number_acc  = push_digit(number_acc, c);
            field_chars = field_chars + 1'b1;
            if (field_chars >= COUNT_CHARS) begin
              pairs_total = number_acc[PAIR_W-1:0];
              pairs_seen  = '0;
              number_acc  = '0;
              field_chars = '0;
              have_x      = 1'b0;
              pen_lifted  = 1'b1;
              phase       = (pairs_total == 0) ? PH_GLYPH : PH_PAIRS;
            end
          end
          PH_PAIRS: begin
            if (!have_x) begin
              held_x = c;
              have_x = 1'b1;
            end else begin
              have_x     = 1'b0;
              first_pair = (pairs_seen == 0);
              pairs_seen = pairs_seen + 1'b1;
              if (pairs_seen >= pairs_total) begin
                phase      = PH_GLYPH;
                pairs_seen = '0;
              end
              // The bounds pair is skipped; space-R lifts the pen
              if (!first_pair) begin
                if (held_x == CHAR_SPACE && c == CHAR_R) begin
                  pen_lifted = 1'b1;
                end else begin
                  fresh.kind    = pen_lifted ? KIND_MOVE : KIND_DRAW;
                  fresh.point_x = place_point(origin_x_q, held_x, scale_q);
                  fresh.point_y = place_point(origin_y_q, c, scale_q);
                  emit          = 1'b1;
                  pen_lifted    = 1'b0;
                end
              end
            end
          end
          default: begin
            phase       = PH_GLYPH;
            number_acc  = push_digit(number_acc, c);
            field_chars = field_chars + 1'b1;
            if (field_chars >= GLYPH_CHARS) begin
              fresh.kind         = KIND_GLYPH;
              fresh.glyph_number = number_acc;
              emit               = 1'b1;
              number_acc         = '0;
              field_chars        = '0;
              phase              = PH_COUNT;
            end
          end
        endcase
        if (emit)
          expected_beats.push_back(fresh);
      end
    end
    fail_count    <= failures;
    beats_waiting <= expected_beats.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : stimulus and verdict for the vector glyph stream decoder
// Feeds directed and random glyph records, noise and broken records through
// the byte channel with random gaps and output stalls, walks the origin and
// scale registers through several settings, and leaves the checking to the
// checker module beside the block.
// ----------------------------------------------------------------------------
module testbench
  import vgsd_pkg::*;
();

  localparam int LIMIT_CYCLES   = 500000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 210;
  localparam int PHASE_COUNT_N  = 6;
  localparam int DRAIN_CYCLES   = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [BYTE_W-1:0]         in_byte_in = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                out_kind;
  logic [GLYPH_W-1:0]        out_glyph_number;
  logic signed [POINT_W-1:0] out_point_x;
  logic signed [POINT_W-1:0] out_point_y;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [ORIGIN_W-1:0]       cfg_wdata = '0;

  int fail_count;
  int beats_waiting;
  int items_sent = 0;
  int cycle_count = 0;
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_active = 1'b0;

  always #2 clk = ~clk;

  vector_glyph_stream_decoder_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_glyph_number (out_glyph_number),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  glyph_stream_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_glyph_number (out_glyph_number),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .beats_waiting    (beats_waiting)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        hold_active  = 1'b0;
      end
      stall = rx_fast ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = (tx_fast || hold_active) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (b != CHAR_LF && b != CHAR_CR)
      items_sent++;
  endtask

  // Now and then slip a line break into the stream
  task automatic maybe_line_break();
    if ($urandom_range(0, 11) == 0)
      send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
  endtask

  // Character near 'R' so points land around the origin
  function automatic logic [BYTE_W-1:0] near_r(int spread);
    int v;
    v = int'(CHAR_R) + int'($urandom_range(0, 2 * spread)) - spread;
    return v[BYTE_W-1:0];
  endfunction

  // One glyph record: number field, count field, bounds pair and strokes
  task automatic send_record();
    int n;
    int r;
    int sent_pairs;
    int digit [3];
    logic [BYTE_W-1:0] ch;
    bit leading;
    for (int i = 0; i < DEF_GLYPH_FIELD_CHARS; i++) begin
      maybe_line_break();
      if ($urandom_range(0, 9) == 0)
        ch = 8'($urandom_range(0, 255));
      else
        ch = CHAR_ZERO + 8'($urandom_range(0, 9));
      send_byte(ch);
    end
    r = $urandom_range(0, 19);
    n = (r == 0) ? 0 : (r < 17) ? $urandom_range(1, 6) : $urandom_range(7, 30);
    digit[0] = n / 100;
    digit[1] = (n / 10) % 10;
    digit[2] = n % 10;
    leading  = 1'b1;
    for (int i = 0; i < DEF_COUNT_FIELD_CHARS; i++) begin
      maybe_line_break();
      if (leading && digit[i] == 0 && i < DEF_COUNT_FIELD_CHARS - 1)
        ch = $urandom_range(0, 3) == 0 ? CHAR_ZERO : CHAR_SPACE;
      else begin
        ch      = CHAR_ZERO + 8'(digit[i]);
        leading = 1'b0;
      end
      send_byte(ch);
    end
    // A broken record stops short and lets the next one fill in
    sent_pairs = ($urandom_range(0, 9) == 0 && n > 1) ? $urandom_range(1, n - 1) : n;
    for (int p = 0; p < sent_pairs; p++) begin
      r = $urandom_range(0, 19);
      if (p == 0) begin
        send_byte(near_r(15));
        send_byte(near_r(15));
      end else if (r < 3) begin
        send_byte(CHAR_SPACE);
        maybe_line_break();
        send_byte(CHAR_R);
      end else if (r < 6) begin
        send_byte(8'($urandom_range(0, 255)));
        maybe_line_break();
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(near_r(25));
        maybe_line_break();
        send_byte(near_r(25));
      end
    end
  endtask

  // Stop offering, wait out every expected beat, then let the pipe drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ORIGIN_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] directed [$];
    directed = '{
      // largest glyph number with a line feed inside, then a zero pair count
      8'h39, 8'h39, CHAR_LF, 8'h39, 8'h39, 8'h39, CHAR_SPACE, CHAR_SPACE, CHAR_ZERO,
      // glyph 7 with a non-digit and a carriage return in the field
      CHAR_ZERO, CHAR_ZERO, 8'h78, CHAR_CR, CHAR_ZERO, 8'h37,
      CHAR_SPACE, CHAR_SPACE, 8'h35,
      // bounds, move and draw at the byte extremes, pen up, move to origin
      8'h80, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, CHAR_SPACE, CHAR_R, CHAR_R, CHAR_R
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_byte(directed[i]);

    for (int ph = 0; ph < PHASE_COUNT_N; ph++) begin
      // Reconfigure only while the block is idle
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin
            write_cfg(CFG_ORIGIN_X, 8'd0);
            write_cfg(CFG_ORIGIN_Y, 8'd0);
            write_cfg(CFG_SCALE, 8'd1);
          end
          2: begin
            write_cfg(CFG_ORIGIN_X, 8'd255);
            write_cfg(CFG_ORIGIN_Y, 8'd255);
            write_cfg(CFG_SCALE, 8'd7);
          end
          3: begin
            write_cfg(CFG_ORIGIN_X, 8'd0);
            write_cfg(CFG_ORIGIN_Y, 8'd255);
            write_cfg(CFG_SCALE, 8'd0);
            write_cfg(CFG_UNUSED, 8'($urandom_range(0, 255)));
          end
          default: begin
            write_cfg(CFG_ORIGIN_X, 8'($urandom_range(0, 255)));
            write_cfg(CFG_ORIGIN_Y, 8'($urandom_range(0, 255)));
            write_cfg(CFG_SCALE, 8'($urandom_range(1, 7)));
          end
        endcase
        cfg_we <= 1'b0;
      end
      rx_fast = ($urandom_range(0, 2) == 0);
      // Hold the result side off so the queue fills and stalls the input
      if (ph == 2)
        hold_off_req = 1'b1;
      while (items_sent < (ph + 1) * PHASE_ITEMS) begin
        tx_fast = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4))
            send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_record();
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
